### rtl/core/hht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht_pkg
// shared constants and a saturating increment for the row activation heavy hitter tracker
// ----------------------------------------------------------------------------
package hht_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int ROW_BITS_DEF = 17;

    localparam int CNT_W = 32;
    localparam int THR_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0] THR_RESET = 16'd1024;

    // item function codes
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hht_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht_in_if
// access channel: function code and row address
// ----------------------------------------------------------------------------
interface hht_in_if #(
    parameter int ROW_W = hht_pkg::ROW_BITS_DEF
);
    logic             valid;
    logic             ready;
    logic             func;
    logic [ROW_W-1:0] row_addr;

    modport source (output valid, output func, output row_addr, input ready);
    modport sink   (input valid, input func, input row_addr, output ready);
endinterface
`default_nettype wire

### rtl/core/hht_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht_out_if
// result channel: mitigation flag
// ----------------------------------------------------------------------------
interface hht_out_if;
    logic valid;
    logic ready;
    logic mitigate;

    modport source (output valid, output mitigate, input ready);
    modport sink   (input valid, input mitigate, output ready);
endinterface
`default_nettype wire

### rtl/core/hht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

### rtl/core/hht_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht_mod
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module hht_mod (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [hht_pkg::CNT_W-1:0] i_dividend,
    input  wire logic [hht_pkg::THR_W-1:0] i_divisor,
    output logic                          o_done,
    output logic                          o_rem_zero
);
    import hht_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_dvd;
    logic [THR_W-1:0]  r_div;
    logic [THR_W:0]    r_rem;

    logic [THR_W:0]    n_shift;
    logic [THR_W:0]    n_rem;

    always_comb begin
        n_shift = {r_rem[THR_W-1:0], r_dvd[CNT_W-1]};
        n_rem   = (n_shift >= {1'b0, r_div}) ? n_shift - {1'b0, r_div} : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CNT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);
endmodule
`default_nettype wire

### rtl/core/row_activation_heavy_hitter_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// row_activation_heavy_hitter_tracker
// misra-gries table of row activation counts for one dram bank
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    func, row_addr
//  o_result   out  valid/ready    mitigate
//  i_cfg_*    in   write enable   mitigation threshold, 16 bits
//
//  an access item scans the table through the single read port of the entry
//  ram, then runs the bit-serial remainder against the threshold when the new
//  count can be a nonzero multiple of it
//  a window-clear item skips both; items are worked one at a time
//  reset is synchronous and needs no clearing pass: a fill count marks the
//  valid entries, which always form a prefix of the table
//  a finished result sits in an output register, so a new item is taken
//  while the previous result still waits on o_result.ready
// ----------------------------------------------------------------------------
module row_activation_heavy_hitter_tracker #(
    parameter int ENTRIES  = hht_pkg::ENTRIES_DEF,
    parameter int ROW_BITS = hht_pkg::ROW_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [hht_pkg::THR_W-1:0] i_cfg_wdata,
    hht_in_if.sink                         i_item,
    hht_out_if.source                      o_result
);
    import hht_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int DATA_W = ROW_BITS + CNT_W;

    // one-hot control states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_MOD    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [THR_W-1:0]    r_thr;
    logic [FILL_W-1:0]   r_fill;      // entries below this index are valid
    logic [CNT_W-1:0]    r_spill;
    logic [ROW_BITS-1:0] r_row;

    // scan bookkeeping
    logic [FILL_W-1:0]   r_issue;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pend_idx;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic                r_cand;
    logic [IDX_W-1:0]    r_cand_idx;

    logic                r_mit;
    logic                r_out_valid;
    logic                r_out_mit;

    // entry ram signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [DATA_W-1:0]   ram_rdata;
    logic [ROW_BITS-1:0] rd_row;
    logic [CNT_W-1:0]    rd_cnt;

    // remainder unit
    logic                mod_start;
    logic                mod_done;
    logic                mod_zero;
    logic [CNT_W-1:0]    n_cnt;

    logic                in_fire;
    logic                out_load;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_result.valid    = r_out_valid;
    assign o_result.mitigate = r_out_mit;

    assign rd_row = ram_rdata[DATA_W-1:CNT_W];
    assign rd_cnt = ram_rdata[CNT_W-1:0];

    // reads happen only in the scan and the single write only in the decide
    // step of the same item, so no two accesses to one entry ever overlap
    assign ram_re = (r_state == S_SCAN) && (r_issue < r_fill);

    hht_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    // the new count is captured by the remainder unit on its start edge
    hht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_cnt),
        .i_divisor  (r_thr),
        .o_done     (mod_done),
        .o_rem_zero (mod_zero)
    );

    // decide step: hit, install into free entry, replace, or spill
    logic do_write;
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hit_idx;
        n_cnt     = sat_inc(r_hit_cnt);
        do_write  = 1'b0;
        if (r_hit) begin
            do_write = 1'b1;
        end else if (r_fill < FILL_W'(ENTRIES)) begin
            do_write  = 1'b1;
            ram_waddr = r_fill[IDX_W-1:0];
            n_cnt     = CNT_W'(1);
        end else if (r_cand) begin
            do_write  = 1'b1;
            ram_waddr = r_cand_idx;
            n_cnt     = sat_inc(r_spill);
        end
        ram_we    = (r_state == S_DECIDE) && do_write;
        ram_wdata = {r_row, n_cnt};
    end

    // mitigation check only needed when the count can be a nonzero multiple
    logic need_mod;
    assign need_mod  = (r_thr != '0) && (n_cnt >= CNT_W'(r_thr));
    assign mod_start = (r_state == S_DECIDE) && do_write && need_mod;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_item.func == FUNC_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!(r_issue < r_fill) && !r_pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = mod_start ? S_MOD : S_DONE;
            S_MOD:    if (mod_done) n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_fill      <= '0;
            r_spill     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (in_fire && i_item.func == FUNC_CLEAR) begin
                r_fill  <= '0;
                r_spill <= '0;
            end
            r_pend <= ram_re;
            if (r_state == S_DECIDE && !r_hit) begin
                if (r_fill < FILL_W'(ENTRIES)) begin
                    r_fill <= r_fill + 1'b1;
                end else if (!r_cand) begin
                    r_spill <= sat_inc(r_spill);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and scan results
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_row   <= i_item.row_addr;
            r_issue <= '0;
            r_hit   <= 1'b0;
            r_cand  <= 1'b0;
            r_mit   <= 1'b0;
        end
        if (ram_re) begin
            r_issue    <= r_issue + 1'b1;
            r_pend_idx <= r_issue[IDX_W-1:0];
        end
        if (r_pend) begin
            // first matching row, first entry whose count equals spillover
            if (!r_hit && rd_row == r_row) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_pend_idx;
                r_hit_cnt <= rd_cnt;
            end
            if (!r_cand && rd_cnt == r_spill) begin
                r_cand     <= 1'b1;
                r_cand_idx <= r_pend_idx;
            end
        end
        if (r_state == S_MOD && mod_done) begin
            r_mit <= mod_zero;
        end
        if (out_load) begin
            r_out_mit <= r_mit;
        end
    end
endmodule
`default_nettype wire

### tb/row_activation_heavy_hitter_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_activation_heavy_hitter_tracker_tb
// self-checking bench for the heavy hitter tracker: a queue-fed driver pushes
// access and window-clear items, a clocked monitor runs a table model of
// every accepted item and checks each mitigate flag in order, while both
// channels stall at random and the threshold moves between phases
// ----------------------------------------------------------------------------
module row_activation_heavy_hitter_tracker_tb;

    import hht_pkg::*;

    localparam int N_ENTRIES = ENTRIES_DEF;
    localparam int ROW_W     = ROW_BITS_DEF;
    localparam int ROW_TOP   = (1 << ROW_W) - 1;

    typedef struct packed {
        logic             func;
        logic [ROW_W-1:0] row;
    } t_activation;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    hht_in_if #(.ROW_W(ROW_W)) item_if ();
    hht_out_if                 result_if ();

    row_activation_heavy_hitter_tracker #(
        .ENTRIES  (N_ENTRIES),
        .ROW_BITS (ROW_W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #5 clk = ~clk;

    // items waiting for the driver, and flags waiting for the result channel
    t_activation pending_acts[$];
    logic        mitigate_expected[$];

    // idle odds in percent, moved by the sequence below
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // set by the monitor when the driven item was taken, consumed at negedge
    bit item_taken = 1'b0;
    int fail_count = 0;

    // shadow copy of the tracker table
    logic             tbl_valid [N_ENTRIES];
    logic [ROW_W-1:0] tbl_row   [N_ENTRIES];
    logic [CNT_W-1:0] tbl_count [N_ENTRIES];
    logic [CNT_W-1:0] spill_model;
    logic [THR_W-1:0] thr_model = THR_RESET;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // applies one item to the shadow table and returns its mitigate flag
    function automatic logic track_activation(input logic func,
                                              input logic [ROW_W-1:0] row);
        int               slot;
        logic [CNT_W-1:0] cnt;
        slot = -1;
        if (func == FUNC_CLEAR) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_row[i]   = '0;
                tbl_count[i] = '0;
            end
            spill_model = '0;
            return 1'b0;
        end
        // tracked row: count up
        for (int i = 0; i < N_ENTRIES && slot < 0; i++) begin
            if (tbl_valid[i] && tbl_row[i] == row) begin
                tbl_count[i] = bump(tbl_count[i]);
                slot = i;
            end
        end
        // free entry: install with count one
        for (int i = 0; i < N_ENTRIES && slot < 0; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_row[i]   = row;
                tbl_count[i] = 1;
                slot = i;
            end
        end
        // entry level with the spillover count: take it over
        for (int i = 0; i < N_ENTRIES && slot < 0; i++) begin
            if (tbl_valid[i] && tbl_count[i] == spill_model) begin
                tbl_row[i]   = row;
                tbl_count[i] = bump(spill_model);
                slot = i;
            end
        end
        // row spilled, nothing tracked
        if (slot < 0) begin
            spill_model = bump(spill_model);
            return 1'b0;
        end
        cnt = tbl_count[slot];
        return (thr_model != '0) && (cnt >= thr_model) && (cnt % thr_model == 0);
    endfunction

    initial begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_row[i]   = '0;
            tbl_count[i] = '0;
        end
        spill_model = '0;
    end

    // driver: holds an item until taken, then pops the next one or idles
    always @(negedge clk) begin
        t_activation nxt;
        logic        nxt_valid;
        nxt       = '{func: item_if.func, row: item_if.row_addr};
        nxt_valid = item_if.valid;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else if (!item_if.valid || item_taken) begin
            nxt_valid = 1'b0;
            if (pending_acts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt       = pending_acts.pop_front();
                nxt_valid = 1'b1;
            end
        end
        item_taken       = 1'b0;
        item_if.valid    <= nxt_valid;
        item_if.func     <= nxt.func;
        item_if.row_addr <= nxt.row;
    end

    // receiver back-pressure
    always @(negedge clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check finished results first, then model newly taken items
    always @(posedge clk) begin
        logic want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (mitigate_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, got mitigate=%0b",
                         $time, result_if.mitigate);
                fail_count++;
            end else begin
                want = mitigate_expected.pop_front();
                if (result_if.mitigate !== want) begin
                    $display("%0t: mitigate mismatch, expected %0b, got %0b",
                             $time, want, result_if.mitigate);
                    fail_count++;
                end
            end
        end
        if (rst_n && item_if.valid && item_if.ready) begin
            mitigate_expected.push_back(track_activation(item_if.func, item_if.row_addr));
            item_taken = 1'b1;
        end
    end

    // block until every queued item is in and every result is out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_acts.size() != 0 || item_if.valid || mitigate_expected.size() != 0)
            @(negedge clk);
    endtask

    // only called once the tracker is drained
    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        thr_model = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly a small hot set plus a cold set wider than the table, so the
    // table fills and entries get replaced or spill; rare window clears and
    // some full-range noise rows
    task automatic queue_random(input int count);
        logic [ROW_W-1:0] hot [4];
        logic [ROW_W-1:0] cold [80];
        int unsigned      pick;
        t_activation      act;
        foreach (hot[i]) hot[i] = ROW_W'($urandom_range(ROW_TOP));
        foreach (cold[i]) cold[i] = ROW_W'($urandom_range(ROW_TOP));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            act.func = FUNC_ACCESS;
            if (pick < 8) begin
                act.func = FUNC_CLEAR;
                act.row  = ROW_W'($urandom_range(ROW_TOP));
            end else if (pick < 80) begin
                act.row = ROW_W'($urandom_range(ROW_TOP));
            end else if (pick < 430) begin
                act.row = hot[$urandom_range(3)];
            end else begin
                act.row = cold[$urandom_range(79)];
            end
            pending_acts.push_back(act);
        end
    endtask

    // test sequence
    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        item_if.valid    = 1'b0;
        item_if.func     = FUNC_ACCESS;
        item_if.row_addr = '0;
        result_if.ready  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles a third of the time, receiver about two thirds
        send_idle_pct = 33;
        recv_idle_pct = 64;
        queue_random(200);
        wait_drained();

        // directed: row extremes, repeated hits, clears mid-run and on an
        // empty table, threshold of two
        write_threshold(16'd2);
        pending_acts.push_back('{func: FUNC_CLEAR,  row: ROW_W'(ROW_TOP)});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: ROW_W'(ROW_TOP)});
        pending_acts.push_back('{func: FUNC_ACCESS, row: ROW_W'(ROW_TOP)});
        pending_acts.push_back('{func: FUNC_ACCESS, row: ROW_W'(17'h15555)});
        pending_acts.push_back('{func: FUNC_ACCESS, row: ROW_W'(17'h0aaaa)});
        pending_acts.push_back('{func: FUNC_CLEAR,  row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: '0});
        pending_acts.push_back('{func: FUNC_CLEAR,  row: ROW_W'(17'h15555)});
        pending_acts.push_back('{func: FUNC_CLEAR,  row: '0});
        pending_acts.push_back('{func: FUNC_ACCESS, row: ROW_W'(ROW_TOP)});
        wait_drained();

        // threshold of one: every tracked access mitigates
        write_threshold(16'd1);
        queue_random(150);
        wait_drained();
        write_threshold(16'd3);
        queue_random(150);
        wait_drained();

        // roles swapped
        send_idle_pct = 64;
        recv_idle_pct = 33;
        // zero threshold never mitigates
        write_threshold(16'd0);
        queue_random(150);
        wait_drained();
        write_threshold(16'hffff);
        queue_random(100);
        wait_drained();
        write_threshold(16'd5);
        queue_random(200);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'd2);
        queue_random(200);
        wait_drained();
        write_threshold(16'd4);
        queue_random(150);
        wait_drained();

        // let any stray result show up
        repeat (N_ENTRIES + 40) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/hht_pkg.sv
rtl/core/hht_in_if.sv
rtl/core/hht_out_if.sv
rtl/core/hht_ram.sv
rtl/core/hht_mod.sv
rtl/core/row_activation_heavy_hitter_tracker.sv
tb/row_activation_heavy_hitter_tracker_tb.sv
